[rtl/dragonfly_minimal_route_hops_assert.svh]
// Assertion macros used by the route block's back end (dfmr_back).
`ifndef DRAGONFLY_MINIMAL_ROUTE_HOPS_ASSERT_SVH
`define DRAGONFLY_MINIMAL_ROUTE_HOPS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DFMR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dfmr assertion failed");

// Next-cycle implication, checked outside reset.
`define DFMR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dfmr assertion failed");

`endif

[rtl/dfmr_pkg.sv]
// Shared types and constants of the dragonfly minimal route block.
`default_nettype none
package dfmr_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_LOOP  = 3'd0;
    localparam logic [2:0] KIND_UP    = 3'd1;
    localparam logic [2:0] KIND_LIMIT = 3'd2;
    localparam logic [2:0] KIND_GREEN = 3'd3;
    localparam logic [2:0] KIND_BLACK = 3'd4;
    localparam logic [2:0] KIND_BLUE  = 3'd5;
    localparam logic [2:0] KIND_DOWN  = 3'd6;
    localparam logic [2:0] KIND_ERROR = 3'd7;

    localparam logic [2:0] CFG_GROUP_COUNT       = 3'd0;
    localparam logic [2:0] CFG_CHASSIS_PER_GROUP = 3'd1;
    localparam logic [2:0] CFG_BLADES_PER_CHASSIS = 3'd2;
    localparam logic [2:0] CFG_NODES_PER_BLADE   = 3'd3;
    localparam logic [2:0] CFG_LOOPBACK_ENABLE   = 3'd4;
    localparam logic [2:0] CFG_LIMITER_ENABLE    = 3'd5;

    typedef struct packed {
        logic [6:0] group_count;
        logic [4:0] chassis_per_group;
        logic [6:0] blades_per_chassis;
        logic [4:0] nodes_per_blade;
        logic       loopback_enable;
        logic       limiter_enable;
    } cfg_t;

    // One decoded request as handed from the front to the back.
    typedef struct packed {
        logic        err;
        logic        loop;
        logic        inter;
        logic        diff;
        logic [3:0]  sn;
        logic [3:0]  tn;
        logic [5:0]  sb;
        logic [5:0]  tb;
        logic [3:0]  sc;
        logic [3:0]  tc;
        logic [5:0]  sg;
        logic [5:0]  tg;
        logic [15:0] src_router;
        logic [15:0] dst_router;
        logic [15:0] base_s;
        logic [15:0] base_t;
        logic [15:0] src;
        logic [15:0] dst;
    } rec_t;

endpackage
`default_nettype wire

[rtl/dfmr_div.sv]
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
`default_nettype none
module dfmr_div #(
    parameter int QW = 16,
    parameter int DW = 7,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [QW-1:0] in_a,
    input  logic [QW-1:0] in_b,
    input  logic [DW-1:0] divisor,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_qa,
    output logic [QW-1:0] out_qb,
    output logic [DW-1:0] out_ra,
    output logic [DW-1:0] out_rb,
    output logic [PW-1:0] out_pay
);

    // The numerator word shifts left; quotient bits enter at the bottom.
    function automatic logic [QW+DW-1:0] div_step(input logic [QW-1:0] num,
                                                  input logic [DW-1:0] rem,
                                                  input logic [DW-1:0] d);
        logic [DW:0] t;
        logic        ge;
        logic [DW:0] r;
        t  = {rem, num[QW-1]};
        ge = (t >= {1'b0, d});
        r  = ge ? (t - {1'b0, d}) : t;
        return {num[QW-2:0], ge, r[DW-1:0]};
    endfunction

    logic          valid_reg [QW];
    logic [QW-1:0] num_a_reg [QW];
    logic [QW-1:0] num_b_reg [QW];
    logic [DW-1:0] rem_a_reg [QW];
    logic [DW-1:0] rem_b_reg [QW];
    logic [PW-1:0] pay_reg   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          v_in;
        logic [QW-1:0] a_in;
        logic [QW-1:0] b_in;
        logic [DW-1:0] ra_in;
        logic [DW-1:0] rb_in;
        logic [PW-1:0] p_in;

        if (s == 0) begin : g_first
            assign v_in  = in_valid;
            assign a_in  = in_a;
            assign b_in  = in_b;
            assign ra_in = '0;
            assign rb_in = '0;
            assign p_in  = in_pay;
        end else begin : g_rest
            assign v_in  = valid_reg[s-1];
            assign a_in  = num_a_reg[s-1];
            assign b_in  = num_b_reg[s-1];
            assign ra_in = rem_a_reg[s-1];
            assign rb_in = rem_b_reg[s-1];
            assign p_in  = pay_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                {num_a_reg[s], rem_a_reg[s]} <= div_step(a_in, ra_in, divisor);
                {num_b_reg[s], rem_b_reg[s]} <= div_step(b_in, rb_in, divisor);
                pay_reg[s] <= p_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_qa    = num_a_reg[QW-1];
    assign out_qb    = num_b_reg[QW-1];
    assign out_ra    = rem_a_reg[QW-1];
    assign out_rb    = rem_b_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule
`default_nettype wire

[rtl/dfmr_front.sv]
// Front end: accepts requests, splits both ids into coordinates and classifies the route.
`default_nettype none
module dfmr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  dfmr_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [15:0]   s_source_node,
    input  logic [15:0]   s_dest_node,
    input  logic          s_source_is_router,
    input  logic          s_dest_is_router,
    input  logic          q_full,
    output logic          push,
    output dfmr_pkg::rec_t push_data
);
    import dfmr_pkg::*;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
    } pa_t;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] q1s;
        logic [15:0] q1t;
        logic [3:0]  sn;
        logic [3:0]  tn;
    } pb_t;

    typedef struct packed {
        pb_t         b;
        logic [15:0] q2s;
        logic [15:0] q2t;
        logic [5:0]  sb;
        logic [5:0]  tb;
    } pc_t;

    logic        en;
    logic        a_valid, b_valid, c_valid;
    logic [15:0] a_qa, a_qb, b_qa, b_qb, c_qa, c_qb;
    logic [6:0]  a_ra, a_rb, b_ra, b_rb, c_ra, c_rb;
    pa_t         a_in, a_out;
    pb_t         b_in, b_out;
    pc_t         c_in, c_out;
    logic        cfg_bad;
    rec_t        rec_next;
    rec_t        rec_reg;
    logic        rec_valid_reg;
    logic [3:0]  sc, tc;
    logic [22:0] prod_s, prod_t;

    // The whole front advances together; a full queue holds it.
    assign en      = !q_full;
    assign s_ready = en;

    assign a_in = '{src: s_source_node, dst: s_dest_node};

    // Router endpoints are taken but produce nothing, so they never become valid.
    dfmr_div #(.QW(16), .DW(7), .PW($bits(pa_t))) u_div_node (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid && !s_source_is_router && !s_dest_is_router),
        .in_a     (s_source_node),
        .in_b     (s_dest_node),
        .divisor  ({2'b00, cfg.nodes_per_blade}),
        .in_pay   (a_in),
        .out_valid(a_valid),
        .out_qa   (a_qa),
        .out_qb   (a_qb),
        .out_ra   (a_ra),
        .out_rb   (a_rb),
        .out_pay  (a_out)
    );

    assign b_in = '{src: a_out.src, dst: a_out.dst, q1s: a_qa, q1t: a_qb,
                    sn: a_ra[3:0], tn: a_rb[3:0]};

    dfmr_div #(.QW(16), .DW(7), .PW($bits(pb_t))) u_div_blade (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_valid),
        .in_a     (a_qa),
        .in_b     (a_qb),
        .divisor  (cfg.blades_per_chassis),
        .in_pay   (b_in),
        .out_valid(b_valid),
        .out_qa   (b_qa),
        .out_qb   (b_qb),
        .out_ra   (b_ra),
        .out_rb   (b_rb),
        .out_pay  (b_out)
    );

    assign c_in = '{b: b_out, q2s: b_qa, q2t: b_qb, sb: b_ra[5:0], tb: b_rb[5:0]};

    dfmr_div #(.QW(16), .DW(7), .PW($bits(pc_t))) u_div_chassis (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (b_valid),
        .in_a     (b_qa),
        .in_b     (b_qb),
        .divisor  ({2'b00, cfg.chassis_per_group}),
        .in_pay   (c_in),
        .out_valid(c_valid),
        .out_qa   (c_qa),
        .out_qb   (c_qb),
        .out_ra   (c_ra),
        .out_rb   (c_rb),
        .out_pay  (c_out)
    );

    assign cfg_bad = (cfg.group_count == 7'd0) || (cfg.group_count > 7'd64) ||
                     (cfg.chassis_per_group == 5'd0) || (cfg.chassis_per_group > 5'd16) ||
                     (cfg.blades_per_chassis == 7'd0) || (cfg.blades_per_chassis > 7'd64) ||
                     (cfg.nodes_per_blade == 5'd0) || (cfg.nodes_per_blade > 5'd16) ||
                     (cfg.group_count > cfg.blades_per_chassis);

    assign sc = c_ra[3:0];
    assign tc = c_rb[3:0];

    // First router of each group: (group * chassis_per_group) * blades_per_chassis.
    assign prod_s = 23'(c_out.q2s - 16'(sc)) * 23'(cfg.blades_per_chassis);
    assign prod_t = 23'(c_out.q2t - 16'(tc)) * 23'(cfg.blades_per_chassis);

    always_comb begin
        rec_next.err        = cfg_bad || (c_qa >= 16'(cfg.group_count)) ||
                              (c_qb >= 16'(cfg.group_count));
        rec_next.loop       = (c_out.b.src == c_out.b.dst) && cfg.loopback_enable;
        rec_next.inter      = (c_qa != c_qb);
        rec_next.diff       = (c_out.b.q1s != c_out.b.q1t);
        rec_next.sn         = c_out.b.sn;
        rec_next.tn         = c_out.b.tn;
        rec_next.sb         = c_out.sb;
        rec_next.tb         = c_out.tb;
        rec_next.sc         = sc;
        rec_next.tc         = tc;
        rec_next.sg         = c_qa[5:0];
        rec_next.tg         = c_qb[5:0];
        rec_next.src_router = c_out.b.q1s;
        rec_next.dst_router = c_out.b.q1t;
        rec_next.base_s     = prod_s[15:0];
        rec_next.base_t     = prod_t[15:0];
        rec_next.src        = c_out.b.src;
        rec_next.dst        = c_out.b.dst;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
        end else if (en) begin
            rec_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg <= rec_next;
        end
    end

    assign push      = en && rec_valid_reg;
    assign push_data = rec_reg;

endmodule
`default_nettype wire

[rtl/dfmr_queue.sv]
// Small register queue of decoded requests between front and back.
`default_nettype none
module dfmr_queue #(
    parameter int DEPTH = dfmr_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dfmr_pkg::rec_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output dfmr_pkg::rec_t head
);
    import dfmr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[rtl/dfmr_back.sv]
// Back end: walks the hop list of each decoded request and drives the result register.
`default_nettype none
`include "dragonfly_minimal_route_hops_assert.svh"
module dfmr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  dfmr_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  dfmr_pkg::rec_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_hop_kind,
    output logic [15:0]    m_router_index,
    output logic [5:0]     m_port_index,
    output logic [15:0]    m_node_id,
    output logic           m_last_hop
);
    import dfmr_pkg::*;

    localparam int NSLOT = 11;

    // Hop slots in route order; lowest pending slot goes out first.
    localparam logic [3:0] SLOT_UP     = 4'd0;
    localparam logic [3:0] SLOT_LIM_S  = 4'd1;
    localparam logic [3:0] SLOT_GREEN1 = 4'd2;
    localparam logic [3:0] SLOT_BLACK1 = 4'd3;
    localparam logic [3:0] SLOT_BLUE   = 4'd4;
    localparam logic [3:0] SLOT_GREEN2 = 4'd5;
    localparam logic [3:0] SLOT_BLACK2 = 4'd6;
    localparam logic [3:0] SLOT_LIM_D  = 4'd7;
    localparam logic [3:0] SLOT_DOWN   = 4'd8;
    localparam logic [3:0] SLOT_LOOP   = 4'd9;
    localparam logic [3:0] SLOT_ERR    = 4'd10;

    rec_t             rec_reg, rec_next;
    logic [NSLOT-1:0] mask_reg, mask_next, new_mask, low, rest;
    logic             active_reg, active_next;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_hop_kind_reg;
    logic [15:0]      m_router_index_reg;
    logic [5:0]       m_port_index_reg;
    logic [15:0]      m_node_id_reg;
    logic             m_last_hop_reg;
    logic             can_emit, fire, done, load;
    logic [3:0]       slot;
    logic [2:0]       kind;
    logic [15:0]      router, node;
    logic [5:0]       port;

    always_comb begin
        new_mask = '0;
        if (head.err) begin
            new_mask[SLOT_ERR] = 1'b1;
        end else if (head.loop) begin
            new_mask[SLOT_LOOP] = 1'b1;
        end else begin
            new_mask[SLOT_UP]     = 1'b1;
            new_mask[SLOT_LIM_S]  = cfg.limiter_enable;
            new_mask[SLOT_GREEN1] = head.diff && head.inter && (head.sb != head.tg);
            new_mask[SLOT_BLACK1] = head.diff && head.inter && (head.sc != 4'd0);
            new_mask[SLOT_BLUE]   = head.diff && head.inter;
            new_mask[SLOT_GREEN2] = head.diff && (head.inter ? (head.tb != head.sg)
                                                             : (head.tb != head.sb));
            new_mask[SLOT_BLACK2] = head.diff && (head.inter ? (head.tc != 4'd0)
                                                             : (head.tc != head.sc));
            new_mask[SLOT_LIM_D]  = cfg.limiter_enable;
            new_mask[SLOT_DOWN]   = 1'b1;
        end
    end

    assign can_emit = !m_valid_reg || m_ready;
    assign fire     = active_reg && can_emit;
    assign low      = mask_reg & (~mask_reg + 1'b1);
    assign rest     = mask_reg & ~low;
    assign done     = fire && (rest == '0);
    assign load     = q_valid && (!active_reg || done);
    assign pop      = load;

    always_comb begin
        slot = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (low[i]) begin
                slot = 4'(i);
            end
        end
    end

    always_comb begin
        kind   = KIND_ERROR;
        router = '0;
        port   = '0;
        node   = '0;
        case (slot)
            SLOT_UP: begin
                kind   = KIND_UP;
                router = rec_reg.src_router;
                port   = 6'(rec_reg.sn);
            end
            SLOT_LIM_S: begin
                kind   = KIND_LIMIT;
                router = rec_reg.src_router;
                port   = 6'(rec_reg.sn);
                node   = rec_reg.src;
            end
            SLOT_GREEN1: begin
                kind   = KIND_GREEN;
                router = rec_reg.src_router;
                port   = rec_reg.tg;
            end
            SLOT_BLACK1: begin
                kind   = KIND_BLACK;
                router = rec_reg.src_router - 16'(rec_reg.sb) + 16'(rec_reg.tg);
            end
            SLOT_BLUE: begin
                kind   = KIND_BLUE;
                router = rec_reg.base_s + 16'(rec_reg.tg);
                port   = rec_reg.tg;
            end
            SLOT_GREEN2: begin
                kind   = KIND_GREEN;
                router = rec_reg.inter ? (rec_reg.base_t + 16'(rec_reg.sg))
                                       : rec_reg.src_router;
                port   = rec_reg.tb;
            end
            SLOT_BLACK2: begin
                kind   = KIND_BLACK;
                router = rec_reg.inter ? (rec_reg.base_t + 16'(rec_reg.tb))
                                       : (rec_reg.src_router - 16'(rec_reg.sb) +
                                          16'(rec_reg.tb));
                port   = 6'(rec_reg.tc);
            end
            SLOT_LIM_D: begin
                kind   = KIND_LIMIT;
                router = rec_reg.dst_router;
                port   = 6'(rec_reg.tn);
                node   = rec_reg.dst;
            end
            SLOT_DOWN: begin
                kind   = KIND_DOWN;
                router = rec_reg.dst_router;
                port   = 6'(rec_reg.tn);
            end
            SLOT_LOOP: begin
                kind   = KIND_LOOP;
                router = rec_reg.src_router;
                port   = 6'(rec_reg.sn);
                node   = rec_reg.src;
            end
            default: begin
                kind = KIND_ERROR;
            end
        endcase
    end

    always_comb begin
        mask_next    = mask_reg;
        rec_next     = rec_reg;
        active_next  = active_reg;
        m_valid_next = m_valid_reg;
        if (fire) begin
            mask_next    = rest;
            m_valid_next = 1'b1;
            if (done) begin
                active_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            mask_next   = new_mask;
            rec_next    = head;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            mask_reg    <= '0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        if (fire) begin
            m_hop_kind_reg     <= kind;
            m_router_index_reg <= router;
            m_port_index_reg   <= port;
            m_node_id_reg      <= node;
            m_last_hop_reg     <= (rest == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hop_kind     = m_hop_kind_reg;
    assign m_router_index = m_router_index_reg;
    assign m_port_index   = m_port_index_reg;
    assign m_node_id      = m_node_id_reg;
    assign m_last_hop     = m_last_hop_reg;

    `DFMR_ASSERT_IMP(a_single_hop_last, aclk, aresetn, m_valid_reg && (m_hop_kind_reg == KIND_ERROR || m_hop_kind_reg == KIND_LOOP), m_last_hop_reg)
    `DFMR_ASSERT_IMP(a_active_has_hops, aclk, aresetn, active_reg, mask_reg != '0)
    `DFMR_ASSERT_NXT(a_stall_holds_hops, aclk, aresetn, active_reg && !can_emit, $stable(mask_reg))
    `DFMR_ASSERT_NXT(a_fire_shows_hop, aclk, aresetn, fire, m_valid_reg)

endmodule
`default_nettype wire

[rtl/dragonfly_minimal_route_hops.sv]
// Top level of the dragonfly minimal route hop generator.
//
// Requests enter on the s_ channel (valid/ready): a source and destination node id
// plus router flags. Each request yields its route as a run of hop results on the
// m_ channel (valid/ready), one hop per transfer, last_hop marking the final one.
// Requests with a router endpoint are taken and yield nothing.
// While the queue is not full, the front accepts one request per cycle into a
// 48-stage divider pipeline (three 16-bit restoring divides, one quotient bit per
// stage) plus one classify stage.
// The back sends one hop per cycle while the receiver takes them, and a request
// yields 1 to 9 hops; that hop walker sets the sustained rate.
// When the receiver stalls, the result register holds and the queue between front
// and back fills; once it is full, s_ready drops and the front pipeline freezes.
// Reset (aresetn low, synchronous) empties the pipeline and queue and loads the
// configuration defaults; configuration is written through cfg_we/cfg_index/cfg_wdata.
`default_nettype none
module dragonfly_minimal_route_hops #(
    parameter int QUEUE_DEPTH = dfmr_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_source_node,
    input  logic [15:0] s_dest_node,
    input  logic        s_source_is_router,
    input  logic        s_dest_is_router,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_hop_kind,
    output logic [15:0] m_router_index,
    output logic [5:0]  m_port_index,
    output logic [15:0] m_node_id,
    output logic        m_last_hop
);
    import dfmr_pkg::*;

    cfg_t cfg_reg;
    logic q_full, push, pop, q_valid;
    rec_t push_data, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{group_count: 7'd1, chassis_per_group: 5'd1,
                         blades_per_chassis: 7'd1, nodes_per_blade: 5'd1,
                         loopback_enable: 1'b0, limiter_enable: 1'b0};
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GROUP_COUNT:        cfg_reg.group_count        <= cfg_wdata;
                CFG_CHASSIS_PER_GROUP:  cfg_reg.chassis_per_group  <= cfg_wdata[4:0];
                CFG_BLADES_PER_CHASSIS: cfg_reg.blades_per_chassis <= cfg_wdata;
                CFG_NODES_PER_BLADE:    cfg_reg.nodes_per_blade    <= cfg_wdata[4:0];
                CFG_LOOPBACK_ENABLE:    cfg_reg.loopback_enable    <= cfg_wdata[0];
                CFG_LIMITER_ENABLE:     cfg_reg.limiter_enable     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    dfmr_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_source_node     (s_source_node),
        .s_dest_node       (s_dest_node),
        .s_source_is_router(s_source_is_router),
        .s_dest_is_router  (s_dest_is_router),
        .q_full            (q_full),
        .push              (push),
        .push_data         (push_data)
    );

    dfmr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    dfmr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hop_kind    (m_hop_kind),
        .m_router_index(m_router_index),
        .m_port_index  (m_port_index),
        .m_node_id     (m_node_id),
        .m_last_hop    (m_last_hop)
    );

endmodule
`default_nettype wire
